// ===== sv/timestamp_nearest_trigger_matcher_core_assert.svh =====
// ----------------------------------------------------------------------------
// Assertion macros for the timestamp nearest-trigger matcher
// Concurrent check wrappers that compile away when NO_ASSERTIONS is set.
// ----------------------------------------------------------------------------
`ifndef TIMESTAMP_NEAREST_TRIGGER_MATCHER_CORE_ASSERT_SVH
`define TIMESTAMP_NEAREST_TRIGGER_MATCHER_CORE_ASSERT_SVH

`ifndef NO_ASSERTIONS
// Checked at every clock edge outside reset.
`define TSNM_ASSERT(lbl, clk, rst, prop, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);
// Checked at every clock edge, reset included.
`define TSNM_ASSERT_ALWAYS(lbl, clk, prop, msg) \
   lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define TSNM_ASSERT(lbl, clk, rst, prop, msg)
`define TSNM_ASSERT_ALWAYS(lbl, clk, prop, msg)
`endif

`endif

// ===== sv/tsnm_pkg.sv =====
// ----------------------------------------------------------------------------
// tsnm_pkg
// Shared constants and types of the timestamp nearest-trigger matcher.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package tsnm_pkg;

   localparam int ENTRY_DEPTH   = 64;
   localparam int TRIGGER_DEPTH = 256;

   localparam int ENTRY_AW = (ENTRY_DEPTH > 1) ? $clog2(ENTRY_DEPTH) : 1;
   localparam int TRIG_AW  = (TRIGGER_DEPTH > 1) ? $clog2(TRIGGER_DEPTH) : 1;
   localparam int ENTRY_CW = $clog2(ENTRY_DEPTH + 1);
   localparam int TRIG_CW  = $clog2(TRIGGER_DEPTH + 1);

   localparam int TOL_W = 39;
   localparam logic [TOL_W-1:0] TOL_RESET    = 39'd400000;
   localparam logic [TOL_W-1:0] SEARCH_LIMIT = 39'd300000000000;

   // Request kinds carried in req_tuser.
   localparam logic [1:0] REQ_PUSH_ENTRY = 2'd0;
   localparam logic [1:0] REQ_PUSH_TRIG  = 2'd1;
   localparam logic [1:0] REQ_CLEAR_TRIG = 2'd2;
   localparam logic [1:0] REQ_RUN_MATCH  = 2'd3;

   // Register indexes on the configuration port.
   localparam logic REG_TOLERANCE = 1'b0;
   localparam logic REG_MATCH_ALL = 1'b1;

   typedef struct packed {
      logic [TOL_W-1:0] tolerance_ns;
      logic             match_all;
   } cfg_type;

endpackage

`default_nettype wire

// ===== sv/tsnm_ram.sv =====
// ----------------------------------------------------------------------------
// tsnm_ram
// Simple dual-port synchronous RAM, one write and one registered read port.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module tsnm_ram #(
   parameter int WIDTH = 64,
   parameter int DEPTH = 64,
   parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  wire logic             clock,
   input  wire logic             wr_en,
   input  wire logic [AW-1:0]    wr_addr,
   input  wire logic [WIDTH-1:0] wr_data,
   input  wire logic             rd_en,
   input  wire logic [AW-1:0]    rd_addr,
   output logic      [WIDTH-1:0] rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];

   // Write port.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   // Registered read port.
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data <= mem[rd_addr];
      end
   end

endmodule

`default_nettype wire

// ===== sv/tsnm_cfg.sv =====
// ----------------------------------------------------------------------------
// tsnm_cfg
// APB register bank holding the match tolerance and the match-all switch.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module tsnm_cfg
   import tsnm_pkg::*;
(
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        csr_psel,
   input  wire logic        csr_penable,
   input  wire logic        csr_pwrite,
   input  wire logic [3:0]  csr_paddr,
   input  wire logic [63:0] csr_pwdata,
   output logic      [63:0] csr_prdata,
   output logic             csr_pready,
   output cfg_type          cfg
);

   cfg_type cfg_ff, cfg_in;
   logic    wr_stb;

   assign csr_pready = 1'b1;
   assign wr_stb     = csr_psel & csr_penable & csr_pwrite;

   // Register writes; address bit 3 selects the register.
   always_comb begin
      cfg_in = cfg_ff;
      if (wr_stb) begin
         case (csr_paddr[3])
            REG_TOLERANCE: cfg_in.tolerance_ns = csr_pwdata[TOL_W-1:0];
            REG_MATCH_ALL: cfg_in.match_all    = csr_pwdata[0];
            default:       cfg_in              = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.tolerance_ns <= TOL_RESET;
         cfg_ff.match_all    <= 1'b0;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   // Read mux.
   always_comb begin
      case (csr_paddr[3])
         REG_TOLERANCE: csr_prdata = {{(64-TOL_W){1'b0}}, cfg_ff.tolerance_ns};
         REG_MATCH_ALL: csr_prdata = {63'd0, cfg_ff.match_all};
         default:       csr_prdata = 64'd0;
      endcase
   end

   assign cfg = cfg_ff;

endmodule

`default_nettype wire

// ===== sv/timestamp_nearest_trigger_matcher_core.sv =====
// ----------------------------------------------------------------------------
// timestamp_nearest_trigger_matcher_core
// Entry and trigger tables in RAM, with a sequencer that pairs entries to the
// nearest eligible trigger and compacts the entry table as it goes.
// ----------------------------------------------------------------------------
//  Channel  Direction  Beat content
//  req_     in         tuser = request kind, tdata = entry/trigger/target
//  rsp_     out        tuser = matched, tlast = last, tdata = pair
//  csr_     in         APB, 64-bit data, tolerance at 0x0, match_all at 0x8
//
//  Push and clear requests are accepted back to back.
//  During a match run the trigger RAM read port delivers one trigger per cycle
//  and a three-stage distance pipeline drains at the end of each entry.
//  Reset is synchronous and clears both counts and the overflow flag.
//  A stalled result beat holds the run until rsp_tready rises.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module timestamp_nearest_trigger_matcher_core
   import tsnm_pkg::*;
(
   input  wire logic         clock,
   input  wire logic         reset,
   // Fields from bit 0: board0_time, board1_time, trigger_time, trigger_word,
   // trigger_track, trigger_group, target_word, target_track.
   input  wire logic [239:0] req_tdata,
   // Fields from bit 0: req_type.
   input  wire logic [1:0]   req_tuser,
   input  wire logic         req_tvalid,
   output logic              req_tready,
   // Fields from bit 0: entry_time, board, paired_trigger_time, paired_track,
   // paired_group, overflow, zero fill.
   output logic      [159:0] rsp_tdata,
   // Fields from bit 0: matched.
   output logic              rsp_tuser,
   output logic              rsp_tlast,
   output logic              rsp_tvalid,
   input  wire logic         rsp_tready,
   input  wire logic         csr_psel,
   input  wire logic         csr_penable,
   input  wire logic         csr_pwrite,
   input  wire logic [3:0]   csr_paddr,
   input  wire logic [63:0]  csr_pwdata,
   output logic      [63:0]  csr_prdata,
   output logic              csr_pready
);

`include "timestamp_nearest_trigger_matcher_core_assert.svh"

   typedef enum logic [5:0] {
      ST_IDLE       = 6'b000001,
      ST_ENTRY_RD   = 6'b000010,
      ST_ENTRY_WAIT = 6'b000100,
      ST_SCAN       = 6'b001000,
      ST_DECIDE     = 6'b010000,
      ST_FINISH     = 6'b100000
   } state_type;

   typedef struct packed {
      logic        matched;
      logic        last;
      logic [63:0] entry_time;
      logic        board;
      logic [63:0] trig_time;
      logic [7:0]  track;
      logic [15:0] group;
      logic        overflow;
   } result_type;

   cfg_type cfg;

   tsnm_cfg u_cfg (
      .clock       (clock),
      .reset       (reset),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready),
      .cfg         (cfg)
   );

   // Request fields.
   logic [63:0] in_b0, in_b1, in_tt;
   logic [7:0]  in_word, in_track, in_tword, in_ttrack;
   logic [15:0] in_group;
   assign in_b0     = req_tdata[63:0];
   assign in_b1     = req_tdata[127:64];
   assign in_tt     = req_tdata[191:128];
   assign in_word   = req_tdata[199:192];
   assign in_track  = req_tdata[207:200];
   assign in_group  = req_tdata[223:208];
   assign in_tword  = req_tdata[231:224];
   assign in_ttrack = req_tdata[239:232];

   // Control registers.
   state_type           state_ff, state_in;
   logic [ENTRY_CW-1:0] entry_count_ff, entry_count_in;
   logic [TRIG_CW-1:0]  trig_count_ff, trig_count_in;
   logic                drop_ff, drop_in;
   logic [ENTRY_CW-1:0] idx_ff, idx_in;
   logic [ENTRY_CW-1:0] keep_ff, keep_in;
   logic [TRIG_CW-1:0]  j_ff, j_in;
   logic                v1_ff, v1_in, v2_ff, v3_ff;
   logic                have_pend_ff, have_pend_in;
   logic                out_valid_ff, out_valid_in;

   // Payload registers.
   logic [7:0]       tword_ff, tword_in, ttrack_ff, ttrack_in;
   logic [63:0]      t0_ff, t0_in, t1_ff, t1_in;
   logic [TOL_W-1:0] best_ff, best_in;
   logic [63:0]      best_et_ff, best_et_in, best_tt_ff, best_tt_in;
   logic             best_bd_ff, best_bd_in;
   logic [31:0]      best_tag_ff, best_tag_in;
   result_type       pend_ff, pend_in, out_ff, out_in;

   // Distance pipeline registers.
   logic [63:0] d0_2_ff, d1_2_ff, tt_2_ff, tt_3_ff;
   logic [31:0] tag_2_ff, tag_3_ff;
   logic        ok_2_ff, ok_3_ff, b0_3_ff, small_3_ff;
   logic [TOL_W-1:0] d_3_ff;

   // RAM ports.
   logic                ent_we, ent_re, trig_we, trig_re;
   logic [ENTRY_AW-1:0] ent_waddr, ent_raddr;
   logic [127:0]        ent_wdata, ent_rdata;
   logic [TRIG_AW-1:0]  trig_waddr, trig_raddr;
   logic [95:0]         trig_wdata, trig_rdata;
   logic                out_load;
   logic                hit;

   tsnm_ram #(.WIDTH(128), .DEPTH(ENTRY_DEPTH)) u_entry_ram (
      .clock   (clock),
      .wr_en   (ent_we),
      .wr_addr (ent_waddr),
      .wr_data (ent_wdata),
      .rd_en   (ent_re),
      .rd_addr (ent_raddr),
      .rd_data (ent_rdata)
   );

   tsnm_ram #(.WIDTH(96), .DEPTH(TRIGGER_DEPTH)) u_trig_ram (
      .clock   (clock),
      .wr_en   (trig_we),
      .wr_addr (trig_waddr),
      .wr_data (trig_wdata),
      .rd_en   (trig_re),
      .rd_addr (trig_raddr),
      .rd_data (trig_rdata)
   );

   assign req_tready = (state_ff == ST_IDLE);
   assign hit        = (best_ff < cfg.tolerance_ns);
   assign trig_raddr = j_ff[TRIG_AW-1:0];
   assign ent_raddr  = idx_ff[ENTRY_AW-1:0];

   // Sequencer.
   always_comb begin
      state_in       = state_ff;
      entry_count_in = entry_count_ff;
      trig_count_in  = trig_count_ff;
      drop_in        = drop_ff;
      idx_in         = idx_ff;
      keep_in        = keep_ff;
      j_in           = j_ff;
      v1_in          = 1'b0;
      have_pend_in   = have_pend_ff;
      tword_in       = tword_ff;
      ttrack_in      = ttrack_ff;
      t0_in          = t0_ff;
      t1_in          = t1_ff;
      pend_in        = pend_ff;
      out_in         = out_ff;
      out_load       = 1'b0;
      ent_we         = 1'b0;
      ent_waddr      = entry_count_ff[ENTRY_AW-1:0];
      ent_wdata      = {in_b1, in_b0};
      ent_re         = 1'b0;
      trig_we        = 1'b0;
      trig_waddr     = trig_count_ff[TRIG_AW-1:0];
      trig_wdata     = {in_group, in_track, in_word, in_tt};
      trig_re        = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            if (req_tvalid) begin
               case (req_tuser)
                  REQ_PUSH_ENTRY: begin
                     if (entry_count_ff < ENTRY_CW'(ENTRY_DEPTH)) begin
                        ent_we         = 1'b1;
                        entry_count_in = entry_count_ff + 1'b1;
                     end else begin
                        drop_in = 1'b1;
                     end
                  end
                  REQ_PUSH_TRIG: begin
                     if (trig_count_ff < TRIG_CW'(TRIGGER_DEPTH)) begin
                        trig_we       = 1'b1;
                        trig_count_in = trig_count_ff + 1'b1;
                     end else begin
                        drop_in = 1'b1;
                     end
                  end
                  REQ_CLEAR_TRIG: begin
                     trig_count_in = '0;
                  end
                  REQ_RUN_MATCH: begin
                     tword_in     = in_tword;
                     ttrack_in    = in_ttrack;
                     idx_in       = '0;
                     keep_in      = '0;
                     have_pend_in = 1'b0;
                     state_in     = ST_ENTRY_RD;
                  end
                  default: state_in = ST_IDLE;
               endcase
            end
         end
         ST_ENTRY_RD: begin
            if (idx_ff == entry_count_ff) begin
               state_in = ST_FINISH;
            end else begin
               ent_re   = 1'b1;
               state_in = ST_ENTRY_WAIT;
            end
         end
         ST_ENTRY_WAIT: begin
            t0_in    = ent_rdata[63:0];
            t1_in    = ent_rdata[127:64];
            j_in     = '0;
            state_in = ST_SCAN;
         end
         ST_SCAN: begin
            if (j_ff != trig_count_ff) begin
               trig_re = 1'b1;
               v1_in   = 1'b1;
               j_in    = j_ff + 1'b1;
            end else if (!v1_ff && !v2_ff && !v3_ff) begin
               state_in = ST_DECIDE;
            end
         end
         ST_DECIDE: begin
            if (hit) begin
               if (!(have_pend_ff && out_valid_ff && !rsp_tready)) begin
                  if (have_pend_ff) begin
                     out_load = 1'b1;
                     out_in   = pend_ff;
                  end
                  pend_in.matched    = 1'b1;
                  pend_in.last       = 1'b0;
                  pend_in.entry_time = best_et_ff;
                  pend_in.board      = best_bd_ff;
                  pend_in.trig_time  = best_tt_ff;
                  pend_in.track      = best_tag_ff[15:8];
                  pend_in.group      = best_tag_ff[31:16];
                  pend_in.overflow   = 1'b0;
                  have_pend_in       = 1'b1;
                  idx_in             = idx_ff + 1'b1;
                  state_in           = ST_ENTRY_RD;
               end
            end else begin
               // Entry stays: compact it down to the keep slot.
               ent_we    = 1'b1;
               ent_waddr = keep_ff[ENTRY_AW-1:0];
               ent_wdata = {t1_ff, t0_ff};
               keep_in   = keep_ff + 1'b1;
               idx_in    = idx_ff + 1'b1;
               state_in  = ST_ENTRY_RD;
            end
         end
         ST_FINISH: begin
            if (!(out_valid_ff && !rsp_tready)) begin
               out_load = 1'b1;
               if (have_pend_ff) begin
                  out_in      = pend_ff;
                  out_in.last = 1'b1;
               end else begin
                  out_in      = '0;
                  out_in.last = 1'b1;
               end
               entry_count_in = keep_ff;
               state_in       = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
      if (out_load) begin
         out_in.overflow = drop_ff;
      end
   end

   assign out_valid_in = out_load | (out_valid_ff & ~rsp_tready);

   // Best-distance tracker at the end of the pipeline.
   always_comb begin
      best_in     = best_ff;
      best_et_in  = best_et_ff;
      best_bd_in  = best_bd_ff;
      best_tt_in  = best_tt_ff;
      best_tag_in = best_tag_ff;
      if (state_ff == ST_ENTRY_WAIT) begin
         best_in     = SEARCH_LIMIT;
         best_et_in  = '0;
         best_bd_in  = 1'b0;
         best_tt_in  = '0;
         best_tag_in = '0;
      end else if (v3_ff && ok_3_ff && small_3_ff && (d_3_ff < best_ff)) begin
         best_in     = d_3_ff;
         best_et_in  = b0_3_ff ? t0_ff : t1_ff;
         best_bd_in  = ~b0_3_ff;
         best_tt_in  = tt_3_ff;
         best_tag_in = tag_3_ff;
      end
   end

   // Control state.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff       <= ST_IDLE;
         entry_count_ff <= '0;
         trig_count_ff  <= '0;
         drop_ff        <= 1'b0;
         idx_ff         <= '0;
         keep_ff        <= '0;
         j_ff           <= '0;
         v1_ff          <= 1'b0;
         v2_ff          <= 1'b0;
         v3_ff          <= 1'b0;
         have_pend_ff   <= 1'b0;
         out_valid_ff   <= 1'b0;
      end else begin
         state_ff       <= state_in;
         entry_count_ff <= entry_count_in;
         trig_count_ff  <= trig_count_in;
         drop_ff        <= drop_in;
         idx_ff         <= idx_in;
         keep_ff        <= keep_in;
         j_ff           <= j_in;
         v1_ff          <= v1_in;
         v2_ff          <= v1_ff;
         v3_ff          <= v2_ff;
         have_pend_ff   <= have_pend_in;
         out_valid_ff   <= out_valid_in;
      end
   end

   // Payload and distance pipeline: stage 2 takes both board distances,
   // stage 3 picks the closer board.
   always_ff @(posedge clock) begin
      tword_ff    <= tword_in;
      ttrack_ff   <= ttrack_in;
      t0_ff       <= t0_in;
      t1_ff       <= t1_in;
      best_ff     <= best_in;
      best_et_ff  <= best_et_in;
      best_bd_ff  <= best_bd_in;
      best_tt_ff  <= best_tt_in;
      best_tag_ff <= best_tag_in;
      pend_ff     <= pend_in;
      out_ff      <= out_in;

      d0_2_ff  <= (t0_ff > trig_rdata[63:0]) ? t0_ff - trig_rdata[63:0]
                                             : trig_rdata[63:0] - t0_ff;
      d1_2_ff  <= (t1_ff > trig_rdata[63:0]) ? t1_ff - trig_rdata[63:0]
                                             : trig_rdata[63:0] - t1_ff;
      tt_2_ff  <= trig_rdata[63:0];
      tag_2_ff <= trig_rdata[95:64];
      ok_2_ff  <= cfg.match_all | ((trig_rdata[71:64] == tword_ff) &&
                                   (trig_rdata[79:72] == ttrack_ff));

      b0_3_ff    <= (d0_2_ff < d1_2_ff);
      if (d0_2_ff < d1_2_ff) begin
         d_3_ff     <= d0_2_ff[TOL_W-1:0];
         small_3_ff <= (d0_2_ff[63:TOL_W] == '0);
      end else begin
         d_3_ff     <= d1_2_ff[TOL_W-1:0];
         small_3_ff <= (d1_2_ff[63:TOL_W] == '0);
      end
      tt_3_ff  <= tt_2_ff;
      tag_3_ff <= tag_2_ff;
      ok_3_ff  <= ok_2_ff;
   end

   // Result beat.
   assign rsp_tvalid = out_valid_ff;
   assign rsp_tuser  = out_ff.matched;
   assign rsp_tlast  = out_ff.last;
   assign rsp_tdata  = {6'd0, out_ff.overflow, out_ff.group, out_ff.track,
                        out_ff.trig_time, out_ff.board, out_ff.entry_time};

   // Checks.
   `TSNM_ASSERT(a_entry_count_range, clock, reset, entry_count_ff <= ENTRY_CW'(ENTRY_DEPTH), "entry count beyond depth")
   `TSNM_ASSERT(a_trig_count_range, clock, reset, trig_count_ff <= TRIG_CW'(TRIGGER_DEPTH), "trigger count beyond depth")
   `TSNM_ASSERT(a_keep_behind_idx, clock, reset, keep_ff <= idx_ff, "compaction slot passed read index")
   `TSNM_ASSERT(a_no_out_overwrite, clock, reset, out_load |-> (!out_valid_ff || rsp_tready), "result register overwritten while stalled")

endmodule

`default_nettype wire

// ===== tb/sv/tb.sv =====
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the timestamp nearest-trigger matcher. A driver and
// a receiver run on the falling edge from a queue of request beats, and a
// monitor on the rising edge predicts every result beat and compares each
// field in order. The stimulus starts with directed cases, then adds a full
// entry table and a full trigger table, and ends with random load and match
// sequences under changing tolerance and match-all settings.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module tb;
   import tsnm_pkg::*;

   localparam int IDLE_LIMIT = 100000;
   localparam int LONG_HOLD  = 400;

   typedef struct {
      logic [1:0]  kind;
      logic [63:0] b0, b1, ttime;
      logic [7:0]  word, track;
      logic [15:0] group;
      logic [7:0]  want_word, want_track;
   } request_type;

   typedef struct {
      logic        matched;
      logic [63:0] entry_time;
      logic        board;
      logic [63:0] ttime;
      logic [7:0]  track;
      logic [15:0] group;
      logic        overflow;
      logic        last;
   } pair_type;

   logic clock = 1'b0;
   logic reset = 1'b1;

   logic [239:0] req_tdata = '0;
   logic [1:0]   req_tuser = '0;
   logic         req_tvalid = 1'b0;
   logic         req_tready;
   logic [159:0] rsp_tdata;
   logic         rsp_tuser, rsp_tlast, rsp_tvalid;
   logic         rsp_tready = 1'b0;
   logic         csr_psel = 1'b0, csr_penable = 1'b0, csr_pwrite = 1'b0;
   logic [3:0]   csr_paddr = '0;
   logic [63:0]  csr_pwdata = '0;
   logic [63:0]  csr_prdata;
   logic         csr_pready;

   timestamp_nearest_trigger_matcher_core uut (.*);

   always #5 clock = ~clock;

   // Shadow copy of the block's tables and registers.
   logic [63:0]      entry_b0[ENTRY_DEPTH];
   logic [63:0]      entry_b1[ENTRY_DEPTH];
   int               entry_n;
   logic [63:0]      trig_time[TRIGGER_DEPTH];
   logic [7:0]       trig_word[TRIGGER_DEPTH];
   logic [7:0]       trig_track[TRIGGER_DEPTH];
   logic [15:0]      trig_group[TRIGGER_DEPTH];
   int               trig_n;
   logic             dropped;
   logic [TOL_W-1:0] tol_shadow;
   logic             all_shadow;

   request_type pending_reqs[$];
   pair_type    expected_pairs[$];
   request_type cur_req;
   int          errors = 0;
   int          idle_cycles = 0;
   logic        req_fire = 1'b0;
   logic        hold_request = 1'b0;

   // Applies one accepted request to the shadow tables and queues its pairs.
   function automatic void predict_request(request_type r);
      pair_type    found[$];
      pair_type    p;
      logic [63:0] best, d0, d1, d;
      logic        near0, hit;
      int          keep;
      case (r.kind)
         REQ_PUSH_ENTRY: begin
            if (entry_n < ENTRY_DEPTH) begin
               entry_b0[entry_n] = r.b0;
               entry_b1[entry_n] = r.b1;
               entry_n++;
            end else begin
               dropped = 1'b1;
            end
         end
         REQ_PUSH_TRIG: begin
            if (trig_n < TRIGGER_DEPTH) begin
               trig_time[trig_n]  = r.ttime;
               trig_word[trig_n]  = r.word;
               trig_track[trig_n] = r.track;
               trig_group[trig_n] = r.group;
               trig_n++;
            end else begin
               dropped = 1'b1;
            end
         end
         REQ_CLEAR_TRIG: trig_n = 0;
         default: begin
            keep = 0;
            for (int i = 0; i < entry_n; i++) begin
               best = 64'(SEARCH_LIMIT);
               hit = 1'b0;
               p = '{default: '0};
               for (int j = 0; j < trig_n; j++) begin
                  if (all_shadow || (trig_word[j] == r.want_word &&
                                     trig_track[j] == r.want_track)) begin
                     d0 = (entry_b0[i] > trig_time[j]) ? entry_b0[i] - trig_time[j]
                                                        : trig_time[j] - entry_b0[i];
                     d1 = (entry_b1[i] > trig_time[j]) ? entry_b1[i] - trig_time[j]
                                                        : trig_time[j] - entry_b1[i];
                     near0 = d0 < d1;
                     d = near0 ? d0 : d1;
                     // Later triggers win only on a strictly smaller distance.
                     if (d < best) begin
                        best = d;
                        p.entry_time = near0 ? entry_b0[i] : entry_b1[i];
                        p.board = ~near0;
                        p.ttime = trig_time[j];
                        p.track = trig_track[j];
                        p.group = trig_group[j];
                     end
                  end
               end
               if (best < {25'b0, tol_shadow}) begin
                  p.matched = 1'b1;
                  found = {found, p};
               end else begin
                  entry_b0[keep] = entry_b0[i];
                  entry_b1[keep] = entry_b1[i];
                  keep++;
               end
            end
            entry_n = keep;
            if (found.size() == 0) begin
               p = '{default: '0};
               found = {found, p};
            end
            found[found.size()-1].last = 1'b1;
            foreach (found[k]) begin
               found[k].overflow = dropped;
               expected_pairs = {expected_pairs, found[k]};
            end
         end
      endcase
   endfunction

   task automatic check_field(string name, logic [63:0] want, logic [63:0] got);
      if (want !== got) begin
         $display("%0t: mismatch in %s, expected %h, actual %h", $time, name, want, got);
         errors++;
      end
   endtask

   // Monitor: checks result beats, then predicts from the request beat.
   always @(posedge clock) begin
      pair_type e;
      req_fire <= req_tvalid && req_tready && !reset;
      if (!reset) begin
         if (rsp_tvalid && rsp_tready) begin
            if (expected_pairs.size() == 0) begin
               $display("%0t: result beat with nothing expected, actual %h", $time,
                        rsp_tdata);
               errors++;
            end else begin
               e = expected_pairs.pop_front();
               check_field("matched", e.matched, rsp_tuser);
               check_field("entry_time", e.entry_time, rsp_tdata[63:0]);
               check_field("board", e.board, rsp_tdata[64]);
               check_field("trigger_time", e.ttime, rsp_tdata[128:65]);
               check_field("track", e.track, rsp_tdata[136:129]);
               check_field("group", e.group, rsp_tdata[152:137]);
               check_field("overflow", e.overflow, rsp_tdata[153]);
               check_field("last", e.last, rsp_tlast);
            end
         end
         if (req_tvalid && req_tready)
            predict_request(cur_req);
         if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready))
            idle_cycles = 0;
         else
            idle_cycles++;
         if (idle_cycles >= IDLE_LIMIT) begin
            $display("RESULT: ERROR");
            $finish;
         end
      end
   end

   // Driver: bursts of request beats separated by random gaps.
   int burst_left = 8;
   int gap_left = 0;
   always @(negedge clock) begin
      if (reset) begin
         req_tvalid <= 1'b0;
      end else if (!req_tvalid || req_fire) begin
         if (gap_left > 0) begin
            gap_left--;
            req_tvalid <= 1'b0;
         end else if (pending_reqs.size() > 0) begin
            cur_req = pending_reqs.pop_front();
            req_tuser <= cur_req.kind;
            req_tdata <= {cur_req.want_track, cur_req.want_word, cur_req.group,
                          cur_req.track, cur_req.word, cur_req.ttime, cur_req.b1,
                          cur_req.b0};
            req_tvalid <= 1'b1;
            burst_left--;
            if (burst_left <= 0) begin
               burst_left = $urandom_range(1, 24);
               gap_left = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
            end
         end else begin
            req_tvalid <= 1'b0;
         end
      end
   end

   // Receiver: a stall mode that is redrawn at random, plus one long hold.
   int hold_left = 0;
   int mode_age = 0;
   int stall_mode = 0;
   always @(negedge clock) begin
      if (hold_request && hold_left == 0) begin
         hold_left = LONG_HOLD;
         hold_request = 1'b0;
      end
      if (++mode_age >= 50) begin
         mode_age = 0;
         stall_mode = $urandom_range(0, 2);
      end
      if (hold_left > 0) begin
         hold_left--;
         rsp_tready <= 1'b0;
      end else begin
         case (stall_mode)
            0: rsp_tready <= 1'b1;
            1: rsp_tready <= $urandom_range(0, 1);
            default: rsp_tready <= ($urandom_range(0, 3) == 0);
         endcase
      end
   end

   function automatic logic [63:0] rand64();
      return {$urandom, $urandom};
   endfunction

   function automatic logic [63:0] near(logic [63:0] base);
      return base + 64'($urandom_range(0, 4000000)) - 64'd2000000;
   endfunction

   task automatic add_entry(logic [63:0] b0, logic [63:0] b1);
      request_type r = '{default: '0};
      r.kind = REQ_PUSH_ENTRY;
      r.b0 = b0;
      r.b1 = b1;
      r.ttime = rand64();
      pending_reqs = {pending_reqs, r};
   endtask

   task automatic add_trigger(logic [63:0] t, logic [7:0] w, logic [7:0] trk,
                              logic [15:0] g);
      request_type r = '{default: '0};
      r.kind = REQ_PUSH_TRIG;
      r.ttime = t;
      r.word = w;
      r.track = trk;
      r.group = g;
      r.b0 = rand64();
      pending_reqs = {pending_reqs, r};
   endtask

   task automatic add_simple(logic [1:0] kind, logic [7:0] w, logic [7:0] trk);
      request_type r = '{default: '0};
      r.kind = kind;
      r.want_word = w;
      r.want_track = trk;
      pending_reqs = {pending_reqs, r};
   endtask

   // Waits until every request is taken and every pair has arrived.
   task automatic drain();
      while (pending_reqs.size() > 0 || req_tvalid || expected_pairs.size() > 0)
         @(posedge clock);
      repeat (20) @(posedge clock);
   endtask

   // Register write through a setup and an access phase, then the shadow copy follows.
   task automatic write_reg(logic index, logic [63:0] value);
      @(negedge clock);
      csr_psel <= 1'b1;
      csr_pwrite <= 1'b1;
      csr_paddr <= {index, 3'b000};
      csr_pwdata <= value;
      @(negedge clock);
      csr_penable <= 1'b1;
      @(negedge clock);
      csr_psel <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite <= 1'b0;
      if (index == REG_TOLERANCE)
         tol_shadow = value[TOL_W-1:0];
      else
         all_shadow = value[0];
   endtask

   initial begin
      logic [63:0] base;
      logic [7:0]  w, trk;
      int          nt;
      entry_n = 0;
      trig_n = 0;
      dropped = 1'b0;
      tol_shadow = TOL_RESET;
      all_shadow = 1'b0;
      repeat (7) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // Directed: ties, extremes, eligibility and an empty trigger table.
      write_reg(REG_TOLERANCE, 64'd1000);
      write_reg(REG_MATCH_ALL, 64'd0);
      add_trigger(64'd9950, 8'd5, 8'd7, 16'hFFFF);
      add_trigger(64'd10050, 8'd5, 8'd7, 16'h0001);
      add_trigger(64'd200, 8'd5, 8'd7, 16'h1234);
      add_trigger(64'hFFFF_FFFF_FFFF_FFF0, 8'hFF, 8'hFF, 16'hFFFF);
      add_trigger(64'd0, 8'd0, 8'd0, 16'd0);
      add_entry(64'd10000, 64'd90000);
      add_entry(64'd100, 64'd300);
      add_entry(64'd0, 64'hFFFF_FFFF_FFFF_FFFF);
      add_simple(REQ_RUN_MATCH, 8'd9, 8'd9);
      add_simple(REQ_RUN_MATCH, 8'd5, 8'd7);
      add_simple(REQ_RUN_MATCH, 8'hFF, 8'hFF);
      add_entry(64'd0, 64'd5000000);
      add_simple(REQ_RUN_MATCH, 8'd0, 8'd0);
      add_simple(REQ_CLEAR_TRIG, 8'd0, 8'd0);
      add_entry(64'd10000, 64'd10000);
      add_simple(REQ_RUN_MATCH, 8'd5, 8'd7);
      drain();

      // Zero tolerance matches nothing; the largest one with match-all flushes.
      write_reg(REG_TOLERANCE, 64'd0);
      add_trigger(64'd10000, 8'd1, 8'd2, 16'd3);
      add_simple(REQ_RUN_MATCH, 8'd1, 8'd2);
      drain();
      write_reg(REG_TOLERANCE, 64'd300000000000);
      write_reg(REG_MATCH_ALL, 64'd1);
      add_simple(REQ_RUN_MATCH, 8'd0, 8'd0);
      drain();

      // Full entry table, drained through a long receiver hold.
      base = rand64();
      add_simple(REQ_CLEAR_TRIG, 8'd0, 8'd0);
      add_trigger(base, 8'hA5, 8'h5A, 16'hBEEF);
      for (int i = 0; i < ENTRY_DEPTH + 2; i++)
         add_entry(near(base), near(base));
      add_simple(REQ_RUN_MATCH, 8'd0, 8'd0);
      hold_request = 1'b1;
      for (int i = 0; i < 6; i++)
         add_entry(near(base), near(base));
      add_simple(REQ_RUN_MATCH, 8'd0, 8'd0);
      drain();

      // Full trigger table.
      add_simple(REQ_CLEAR_TRIG, 8'd0, 8'd0);
      for (int i = 0; i < TRIGGER_DEPTH + 1; i++)
         add_trigger(near(base), 8'($urandom), 8'($urandom), 16'($urandom));
      add_entry(near(base), near(base));
      add_entry(near(base), near(base));
      add_simple(REQ_RUN_MATCH, 8'd0, 8'd0);
      add_simple(REQ_CLEAR_TRIG, 8'd0, 8'd0);
      drain();

      // Random sequences; registers change only once every pair is back.
      for (int phase = 0; phase < 4; phase++) begin
         case (phase % 4)
            0: write_reg(REG_TOLERANCE, 64'd400000);
            1: write_reg(REG_TOLERANCE, 64'($urandom_range(0, 3000000)));
            2: write_reg(REG_TOLERANCE, rand64());
            default: write_reg(REG_TOLERANCE, 64'd300000000000);
         endcase
         write_reg(REG_MATCH_ALL, 64'($urandom_range(0, 1)));
         base = rand64();
         w = 8'($urandom_range(0, 3));
         trk = 8'($urandom_range(0, 3));
         if ($urandom_range(0, 2) == 0)
            add_simple(REQ_CLEAR_TRIG, 8'($urandom), 8'($urandom));
         nt = $urandom_range(1, 6);
         for (int k = 0; k < nt; k++)
            add_trigger(near(base), ($urandom_range(0, 3) == 0) ? 8'($urandom) : w,
                        ($urandom_range(0, 3) == 0) ? 8'($urandom) : trk,
                        16'($urandom));
         for (int k = $urandom_range(1, 4); k > 0; k--)
            add_entry(near(base), near(base));
         // Occasional noise beats with arbitrary content.
         if ($urandom_range(0, 4) == 0)
            add_trigger(rand64(), 8'($urandom), 8'($urandom), 16'($urandom));
         if ($urandom_range(0, 6) == 0)
            add_entry(rand64(), rand64());
         add_simple(REQ_RUN_MATCH, w, trk);
         if ($urandom_range(0, 3) == 0)
            add_simple(REQ_RUN_MATCH, 8'($urandom), 8'($urandom));
         drain();
      end

      if (errors == 0)
         $display("RESULT: OK");
      else
         $display("RESULT: ERROR");
      $finish;
   end

endmodule

`default_nettype wire

// ===== timestamp_nearest_trigger_matcher_core.f =====
+incdir+sv
sv/tsnm_pkg.sv
sv/tsnm_ram.sv
sv/tsnm_cfg.sv
sv/timestamp_nearest_trigger_matcher_core.sv
tb/sv/tb.sv
